### hw/rtl/sml_pkg.sv
// Shared types and constants for the substring match locator.
package sml_pkg;

  localparam int CHAR_W      = 8;
  localparam int PATTERN_W   = 64;
  localparam int LENGTH_W    = 4;
  localparam int COUNT_W     = 16;
  localparam int START_W     = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_DATA_W  = 64;

  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_PATTERN_BYTES  = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } cfg_index_t;

  // shift control handed to every cell of the window chain
  typedef struct packed {
    logic adv;  // a request is taken this cycle
    logic clr;  // it closes the text, window empties
  } sml_shift_t;

endpackage

### hw/rtl/substring_match_locator_top.sv
// Top level of the substring match locator: window cell chain and match tracking.
//
// Usage:
//   Text enters on the in_ stream, one character per request, in_tlast on the
//   final character of a text. Every request yields exactly one result on the
//   out_ stream: a match flag, the match start position and the running match
//   count, with out_tlast echoing the text end and out_tuser flagging that the
//   text ran past the position range.
//   The pattern (up to MAX_PATTERN bytes, first character in the low byte) and
//   its length are written on the cfg_ port while no text is in flight.
//   Each result is registered, offered the cycle after its request is taken.
//   Throughput: one character per clock while the receiver keeps up; the
//   cell chain compare and the position/overlap check are combinational.
//   Matches are leftmost and non-overlapping: a hit counts only if it starts
//   at or after the end of the previous counted hit.
//   Reset (rst_n low, synchronous) clears the window, counters and output
//   valid flag and loads pattern 0 with length 1. Text state also clears after
//   each in_tlast character.
//   When the receiver stalls, the result waits in the output register and
//   in_tready drops until it is taken; a new request is taken in the same
//   cycle as the waiting result leaves.
module substring_match_locator_top #(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sml_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] text_char
  input  logic                              in_tlast,   // text_last
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] match_found, [16:1] match_start, [32:17] match_total, [39:33] zero
  output logic [sml_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,  // text_done
  output logic                              out_tuser,  // position_overflow
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  sml_pkg::cfg_index_t               cfg_index,
  input  logic [sml_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sml_pkg::*;

  localparam int SW = POSITION_BITS + 1;
  localparam logic [POSITION_BITS-1:0] POS_TOP = '1;
  localparam logic [LENGTH_W-1:0] MAX_LEN = LENGTH_W'(MAX_PATTERN);

  // ---------------- configuration ----------------
  logic [PATTERN_W-1:0] pattern_bytes_r, pattern_bytes_nxt;
  logic [LENGTH_W-1:0]  pattern_length_r, pattern_length_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    pattern_bytes_nxt  = pattern_bytes_r;
    pattern_length_nxt = pattern_length_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:  pattern_bytes_nxt  = cfg_data[PATTERN_W-1:0];
        CFG_PATTERN_LENGTH: pattern_length_nxt = cfg_data[LENGTH_W-1:0];
        default:            pattern_bytes_nxt  = pattern_bytes_r;
      endcase
    end
  end

  // lengths above the cell count behave as a full-length pattern
  logic [LENGTH_W-1:0] len_c;
  assign len_c = (pattern_length_r > MAX_LEN) ? MAX_LEN : pattern_length_r;

  // ---------------- handshake ----------------
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  sml_shift_t shift;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign shift     = '{adv: accept, clr: in_tlast};

  // ---------------- window cell chain ----------------
  // Cell k compares the character k places back from the newest; the newest
  // character lines up with the last pattern byte.
  logic [MAX_PATTERN-1:0][CHAR_W-1:0] chain;
  logic [MAX_PATTERN-1:0][CHAR_W-1:0] want;
  logic [MAX_PATTERN-1:0]             active;
  logic [MAX_PATTERN-1:0]             cell_hit;

  assign chain[0] = in_tdata[CHAR_W-1:0];

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    logic [LENGTH_W-1:0] idx;
    assign idx       = len_c - LENGTH_W'(g) - LENGTH_W'(1);
    assign active[g] = (LENGTH_W'(g) < len_c);
    assign want[g]   = pattern_bytes_r[CHAR_W*idx[2:0] +: CHAR_W];

    if (g < MAX_PATTERN - 1) begin : g_mid
      sml_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .char_in  (chain[g]),
        .want     (want[g]),
        .active   (active[g]),
        .char_out (chain[g+1]),
        .hit      (cell_hit[g])
      );
    end else begin : g_end
      sml_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .char_in  (chain[g]),
        .want     (want[g]),
        .active   (active[g]),
        .char_out (),
        .hit      (cell_hit[g])
      );
    end
  end

  // ---------------- position and overlap tracking ----------------
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [SW-1:0]            earliest_r, earliest_nxt;
  logic [COUNT_W-1:0]       count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;

  logic [SW-1:0]    pos_inc;
  logic [SW-1:0]    len_ext;
  logic [SW-1:0]    start_s;
  logic             hit;
  logic [COUNT_W-1:0] count_upd;
  logic [SW+START_W-1:0] start_ext;

  assign pos_inc = {1'b0, pos_r} + SW'(1);
  assign len_ext = SW'(len_c);
  assign start_s = pos_inc - len_ext;
  // non-empty pattern; window inside text, clear of last match; all bytes equal
  assign hit = (len_c != '0) && (pos_inc >= len_ext) && (start_s >= earliest_r)
               && (&cell_hit);
  assign count_upd = (hit && (count_r != COUNT_TOP)) ? count_r + COUNT_W'(1) : count_r;
  assign start_ext = {{START_W{1'b0}}, (hit ? start_s : '0)};

  always_comb begin
    pos_nxt      = pos_r;
    earliest_nxt = earliest_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    if (accept) begin
      if (in_tlast) begin
        pos_nxt      = '0;
        earliest_nxt = '0;
        count_nxt    = '0;
        ovf_nxt      = 1'b0;
      end else begin
        earliest_nxt = hit ? pos_inc : earliest_r;
        count_nxt    = count_upd;
        // position saturates at the top; overflow marks later characters
        if (pos_r != POS_TOP) begin
          pos_nxt = pos_r + POSITION_BITS'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic                    found_r, found_nxt;
  logic [START_W-1:0]      start_r, start_nxt;
  logic [COUNT_W-1:0]      total_r, total_nxt;
  logic                    done_r, done_nxt;
  logic                    oflag_r, oflag_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    start_nxt     = start_r;
    total_nxt     = total_r;
    done_nxt      = done_r;
    oflag_nxt     = oflag_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      found_nxt     = hit;
      start_nxt     = start_ext[START_W-1:0];
      total_nxt     = count_upd;
      done_nxt      = in_tlast;
      oflag_nxt     = ovf_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r  <= '0;
      pattern_length_r <= LENGTH_W'(1);
      pos_r            <= '0;
      earliest_r       <= '0;
      count_r          <= '0;
      ovf_r            <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      pattern_bytes_r  <= pattern_bytes_nxt;
      pattern_length_r <= pattern_length_nxt;
      pos_r            <= pos_nxt;
      earliest_r       <= earliest_nxt;
      count_r          <= count_nxt;
      ovf_r            <= ovf_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    start_r <= start_nxt;
    total_r <= total_nxt;
    done_r  <= done_nxt;
    oflag_r <= oflag_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 1 - START_W - COUNT_W){1'b0}},
                       total_r, start_r, found_r};
  assign out_tlast  = done_r;
  assign out_tuser  = oflag_r;

  // ---------------- assertions ----------------
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("request taken while a result is stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  a_text_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (pos_r == '0 && count_r == '0 && earliest_r == '0))
    else $error("text state not cleared after last character");

  a_found_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && found_r) |-> (total_r != '0))
    else $error("match reported with zero total");

  a_ovf_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (pos_r == POS_TOP))
    else $error("overflow flag set below the top position");

endmodule

### hw/rtl/sml_cell.sv
// One byte cell of the sliding character window with its pattern compare.
module sml_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sml_pkg::sml_shift_t      shift,
  input  logic [sml_pkg::CHAR_W-1:0] char_in,
  input  logic [sml_pkg::CHAR_W-1:0] want,
  input  logic                     active,
  output logic [sml_pkg::CHAR_W-1:0] char_out,
  output logic                     hit
);
  import sml_pkg::*;

  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] char_nxt;

  // compare the byte entering this cell against its pattern byte
  assign hit = !active || (char_in == want);

  always_comb begin
    char_nxt = char_r;
    if (shift.adv) begin
      char_nxt = shift.clr ? '0 : char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_r <= '0;
    end else begin
      char_r <= char_nxt;
    end
  end

  assign char_out = char_r;

endmodule

### sim/tb_substring_match_locator_top.sv
// Self-checking testbench for the substring match locator: directed, stall and random texts.
module tb_substring_match_locator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sml_pkg::*;

  localparam int MAX_LEN = 8;
  localparam logic [15:0] POS_TOP = 16'hFFFF;
  localparam int STALL_LIMIT = 1000;  // cycles with no transfer on any channel
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off

  // one result as the block reports it
  typedef struct packed {
    logic found;
    logic [15:0] start;
    logic [15:0] total;
    logic done;
    logic ovf;
  } match_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  cfg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state, mirrors the block
  logic [63:0] pat_bytes;
  logic [3:0] pat_len;
  logic [63:0] window;
  logic [15:0] position;
  logic [16:0] next_start;
  logic [15:0] hits;
  logic ovf_seen;

  match_result_t pending_results[$];
  int errors;

  // stimulus side copy of the current pattern and idle knobs
  logic [63:0] stim_pat;
  logic [3:0] stim_len;
  bit idle_on;
  int gap_pct;
  int stall_pct;
  bit hold_req;

  substring_match_locator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_text();
    window = '0;
    position = '0;
    next_start = '0;
    hits = '0;
    ovf_seen = 1'b0;
  endfunction

  // advance the search by one character and return the result it yields
  function automatic match_result_t scan_char(logic [7:0] ch, logic last);
    match_result_t r;
    int len;
    int k;
    logic [16:0] s;
    logic same;
    r = '0;
    len = (pat_len > MAX_LEN) ? MAX_LEN : int'(pat_len);
    window = {window[55:0], ch};
    r.ovf = ovf_seen;
    r.done = last;
    if (len != 0 && int'(position) + 1 >= len) begin
      s = 17'(int'(position) + 1 - len);
      same = 1'b1;
      // newest character sits in the low byte, pattern starts in the low byte
      for (k = 0; k < len; k++) begin
        if (window[8*k +: 8] != pat_bytes[8*(len-1-k) +: 8]) begin
          same = 1'b0;
        end
      end
      // leftmost non-overlapping: must start at or after the last match end
      if (s >= next_start && same) begin
        r.found = 1'b1;
        r.start = s[15:0];
        next_start = 17'(position) + 17'd1;
        if (hits != COUNT_TOP) begin
          hits = hits + 16'd1;
        end
      end
    end
    // position saturates at the top, later characters flag overflow
    if (position != POS_TOP) begin
      position = position + 16'd1;
    end else begin
      ovf_seen = 1'b1;
    end
    r.total = hits;
    if (last) begin
      clear_text();
    end
    return r;
  endfunction

  function automatic void note_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------- monitor
  // Result check first, then the new request, then register writes, so the
  // order of processes within one edge never matters.
  always @(posedge clk) begin : monitor
    match_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending, expected none actual %h", $time,
                   out_tdata);
        end else begin
          want = pending_results.pop_front();
          note_field("match_found", 16'(want.found), 16'(out_tdata[0]));
          note_field("match_start", want.start, out_tdata[16:1]);
          note_field("match_total", want.total, out_tdata[32:17]);
          note_field("tdata padding", 16'd0, 16'(out_tdata[39:33]));
          note_field("text_done", 16'(want.done), 16'(out_tlast));
          note_field("position_overflow", 16'(want.ovf), 16'(out_tuser));
        end
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(scan_char(in_tdata[7:0], in_tlast));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN_BYTES: begin
            pat_bytes = cfg_data;
          end
          CFG_PATTERN_LENGTH: begin
            pat_len = cfg_data[LENGTH_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // Random stall bursts; a hold request parks out_tready low for a long
  // stretch so the output register fills and in_tready drops.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready = 1'b1;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // offer one character; valid stays high afterwards unless a gap follows
  task automatic send_char(logic [7:0] ch, logic last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tdata = ch;
    in_tlast = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and let every pending result come out
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // only written with the block idle; upper length bits carry junk
  task automatic set_pattern(logic [63:0] pat, logic [3:0] len);
    logic [63:0] len_word;
    drain();
    len_word = {$urandom, $urandom};
    len_word[3:0] = len;
    write_reg(CFG_PATTERN_BYTES, pat);
    write_reg(CFG_PATTERN_LENGTH, len_word);
    stim_pat = pat;
    stim_len = len;
  endtask

  // text mostly built from the pattern: whole copies (some corrupted),
  // pattern characters, and a share of arbitrary bytes
  task automatic send_text(int n);
    logic [7:0] queued[$];
    logic [7:0] ch;
    int plen;
    int k;
    int j;
    plen = (stim_len > MAX_LEN) ? MAX_LEN : int'(stim_len);
    if (plen == 0) begin
      plen = 1;
    end
    for (k = 0; k < n; k++) begin
      if (queued.size() == 0 && $urandom_range(0, 99) < 35) begin
        for (j = 0; j < plen; j++) begin
          queued.push_back(stim_pat[8*j +: 8]);
        end
        if ($urandom_range(0, 99) < 15) begin
          queued[$urandom_range(0, plen - 1)] = 8'($urandom);
        end
      end
      if (queued.size() != 0) begin
        ch = queued.pop_front();
      end else if ($urandom_range(0, 3) != 0) begin
        ch = stim_pat[8*$urandom_range(0, plen - 1) +: 8];
      end else begin
        ch = 8'($urandom_range(0, 255));
      end
      send_char(ch, k == n - 1);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    string txt;
    int k;
    idle_on = 1'b1;
    gap_pct = 30;
    stall_pct = 30;
    // reset settings: all-zero pattern of length one, zero bytes match
    send_char(8'h00, 1'b0);
    send_char(8'h01, 1'b0);
    send_char(8'h00, 1'b1);
    // overlapping candidates: only starts 0 and 4 count
    set_pattern(64'h0000_0000_0061_6261, 4'd3);
    txt = "abababa";
    for (k = 0; k < txt.len(); k++) begin
      send_char(txt[k], k == txt.len() - 1);
    end
    // length above the window size acts as full width
    set_pattern('1, 4'd15);
    for (k = 0; k < 9; k++) begin
      send_char(8'hFF, k == 8);
    end
    // empty pattern never matches
    set_pattern(64'h0123_4567_89AB_CDEF, 4'd0);
    send_char(8'hFF, 1'b0);
    send_char(8'hEF, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_stall_fill();
    int k;
    set_pattern(64'h0000_0000_0000_6161, 4'd2);
    idle_on = 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    for (k = 0; k < 24; k++) begin
      send_char((k % 3 == 2) ? 8'h62 : 8'h61, k == 23);
    end
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random_texts(int n_items, bit with_idle);
    logic [7:0] alpha[4];
    logic [63:0] pat;
    logic [3:0] len;
    int nalpha;
    int sent;
    int texts;
    int n;
    int j;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      nalpha = $urandom_range(2, 4);
      for (j = 0; j < 4; j++) begin
        alpha[j] = 8'($urandom_range(0, 255));
      end
      for (j = 0; j < 8; j++) begin
        pat[8*j +: 8] = alpha[$urandom_range(0, nalpha - 1)];
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        len = 4'd0;
      end else if (pick == 1) begin
        len = 4'($urandom_range(9, 15));
      end else begin
        len = 4'($urandom_range(1, 8));
      end
      set_pattern(pat, len);
      idle_on = with_idle;
      pick = $urandom_range(0, 2);
      gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
      pick = $urandom_range(0, 2);
      stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
      for (texts = $urandom_range(1, 4); texts > 0; texts--) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
        send_text(n);
        sent += n;
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PATTERN_BYTES;
    cfg_data = '0;
    errors = 0;
    idle_on = 1'b1;
    gap_pct = 20;
    stall_pct = 20;
    hold_req = 1'b0;
    stim_pat = '0;
    stim_len = 4'd1;
    pat_bytes = '0;
    pat_len = 4'd1;
    clear_text();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_stall_fill();
    test_random_texts(900, 1'b1);
    // closing part runs without idling
    idle_on = 1'b0;
    test_random_texts(250, 1'b0);
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sml_pkg.sv
hw/rtl/sml_cell.sv
hw/rtl/substring_match_locator_top.sv
sim/tb_substring_match_locator_top.sv
